[rtl/core/tcce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// shared types and constants of the text console character engine
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int PADDR_W = 2;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLS);

  // character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL_UP = 8'h80;

  localparam logic [7:0]        DEFAULT_ATTR = 8'h4F;
  localparam logic [CELL_W-1:0] RESET_CELL   = {DEFAULT_ATTR, CH_SPACE};

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_ATTR = 2'd0;

  // request codes
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    KIND_INIT   = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_SCROLL = 2'd2
  } sweep_kind_e;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_location;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic sweep_en;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_sweep;
    logic sweep_last;
  } dp_sts_t;

endpackage

[rtl/core/text_console_char_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine
// 80x25 text cell store with cursor, fed one character per transfer
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries one request per transfer:
//   a put of a character byte or a read of one cell by linear index.
//   output channel (out_valid_o / out_stall_i) returns exactly one result per
//   request: cursor column, row, linear location and, for a read, the cell.
//   color attribute is written over the apb port at byte address 0; the user
//   is to do so only while the engine is idle, the engine does not enforce it.
// timing:
//   plain put or read: executed in ST_EXEC, result loaded from ST_DONE; the
//   next request is taken the cycle after the result is loaded.
//   form feed and scroll sweep the whole store through its read and write
//   ports, one cell per cycle, then pass ST_FLUSH before the result is loaded.
// reset:
//   after reset the store is cleared to 0x4F20, one cell per cycle, and the
//   input stays stalled until ST_IDLE; apb writes are taken meanwhile.
// stall:
//   a stalled result holds in the output register; the engine finishes the
//   next request and waits with it until the output register frees up.
// ----------------------------------------------------------------------------
module text_console_char_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tcce_pkg::in_item_t                   in_data_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tcce_pkg::out_item_t                  out_data_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import tcce_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic       cfg_we;
  logic [7:0] attr;

  // apb access phase, single register, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == ADDR_ATTR);
  assign prdata = (paddr == ADDR_ATTR) ? {24'h0, attr} : 32'h0;

  // sequencer
  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // store, cursor and result register
  tcce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[7:0]),
    .attr_o      (attr),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/tcce_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_dp
// cell store, cursor, sweep engine and result register
// ----------------------------------------------------------------------------
module tcce_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcce_pkg::dp_cmd_t   cmd_i,
  output tcce_pkg::dp_sts_t   sts_o,
  input  tcce_pkg::in_item_t  in_data_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output logic [7:0]          attr_o,
  output tcce_pkg::out_item_t out_data_o
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem_q [CELLS];

  in_item_t          req_q;
  logic [7:0]        attr_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  sweep_kind_e       kind_q;
  logic [ADDR_W-1:0] sweep_q;
  logic [CELL_W-1:0] rd_data_q;
  logic              wr_en_q;
  logic              wr_copy_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [CELL_W-1:0] wr_data_q;
  out_item_t         out_q;

  logic [7:0]        attr_eff;
  logic [CELL_W-1:0] blank;
  logic              idx_ok;
  logic              copy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W-1:0]  col_d;
  logic [ROW_W-1:0]  row_d;
  logic [COL_W-1:0]  wcol;
  logic [COL_W-1:0]  tab_sum;
  logic              exec_we;
  logic [CELL_W-1:0] exec_data;
  logic [ADDR_W-1:0] exec_addr;
  logic              is_ff;
  logic              scroll;

  assign attr_eff = (attr_q == 8'h00) ? DEFAULT_ATTR : attr_q;
  assign blank    = {attr_eff, CH_SPACE};
  assign idx_ok   = req_q.cell_index < ADDR_W'(CELLS);
  assign tab_sum  = col_q + COL_W'(8);
  assign is_ff    = req_q.char_code == CH_FF;

  // put decode: cursor motion and the single cell write
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    wcol      = col_q;
    exec_we   = 1'b0;
    exec_data = blank;
    scroll    = 1'b0;
    case (req_q.char_code)
      CH_BS: begin
        if (col_q != '0) begin
          col_d   = col_q - COL_W'(1);
          wcol    = col_q - COL_W'(1);
          exec_we = 1'b1;
        end
      end
      CH_TAB: col_d = {tab_sum[COL_W-1:3], 3'b000};
      CH_CR:  col_d = '0;
      CH_LF: begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end
      CH_FF: begin
        col_d = '0;
        row_d = '0;
      end
      default: begin
        if (req_q.char_code >= CH_SPACE && req_q.char_code < CH_DEL_UP) begin
          exec_we   = 1'b1;
          exec_data = {attr_eff, req_q.char_code};
          col_d     = col_q + COL_W'(1);
        end
      end
    endcase
    if (col_d >= COL_W'(COLS)) begin
      col_d = '0;
      row_d = row_d + ROW_W'(1);
    end
    if (row_d >= ROW_W'(ROWS)) begin
      scroll = 1'b1;
      row_d  = ROW_W'(ROWS - 1);
    end
    if (req_q.req_type != REQ_PUT) begin
      exec_we = 1'b0;
    end
  end

  assign exec_addr = ADDR_W'(row_q) * ADDR_W'(COLS) + ADDR_W'(wcol);

  assign copy    = (kind_q == KIND_SCROLL) && (sweep_q < COPY_END);
  assign rd_en   = cmd_i.sweep_en ? copy
                                  : (cmd_i.exec && req_q.req_type == REQ_READ && idx_ok);
  assign rd_addr = cmd_i.sweep_en ? sweep_q + ADDR_W'(COLS) : req_q.cell_index;

  assign sts_o.is_read    = req_q.req_type == REQ_READ;
  assign sts_o.need_sweep = (req_q.req_type == REQ_PUT) && (is_ff || scroll);
  assign sts_o.sweep_last = sweep_q == LAST_CELL;

  // store: one registered read port, one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (wr_en_q) begin
      mem_q[wr_addr_q] <= wr_copy_q ? rd_data_q : wr_data_q;
    end else if (cmd_i.exec && exec_we) begin
      mem_q[exec_addr] <= exec_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q  <= DEFAULT_ATTR;
      col_q   <= '0;
      row_q   <= '0;
      kind_q  <= KIND_INIT;
      sweep_q <= '0;
      wr_en_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (cmd_i.exec && req_q.req_type == REQ_PUT) begin
        col_q  <= col_d;
        row_q  <= row_d;
        kind_q <= is_ff ? KIND_FILL : KIND_SCROLL;
      end
      sweep_q <= cmd_i.sweep_en ? sweep_q + ADDR_W'(1) : '0;
      wr_en_q <= cmd_i.sweep_en;
    end
  end

  // sweep write pipeline and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.sweep_en) begin
      wr_addr_q <= sweep_q;
      wr_copy_q <= copy;
      wr_data_q <= (kind_q == KIND_INIT) ? RESET_CELL : blank;
    end
    if (cmd_i.load_out) begin
      out_q.cursor_col      <= col_q;
      out_q.cursor_row      <= row_q;
      out_q.cursor_location <= ADDR_W'(row_q) * ADDR_W'(COLS) + ADDR_W'(col_q);
      out_q.cell_data       <= (req_q.req_type == REQ_READ && idx_ok) ? rd_data_q : '0;
    end
  end

  assign attr_o     = attr_q;
  assign out_data_o = out_q;

endmodule

[rtl/core/tcce_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl
// sequencer for the console engine: init clear, execute, sweep, result
// ----------------------------------------------------------------------------
module tcce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tcce_pkg::dp_sts_t sts_i,
  output tcce_pkg::dp_cmd_t cmd_o
);
  import tcce_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT     = 7'b0000001,
    ST_INIT_END = 7'b0000010,
    ST_IDLE     = 7'b0000100,
    ST_EXEC     = 7'b0001000,
    ST_SWEEP    = 7'b0010000,
    ST_FLUSH    = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:     if (sts_i.sweep_last) state_d = ST_INIT_END;
      ST_INIT_END: state_d = ST_IDLE;
      ST_IDLE:     if (accept) state_d = ST_EXEC;
      ST_EXEC:     state_d = (!sts_i.is_read && sts_i.need_sweep) ? ST_SWEEP : ST_DONE;
      ST_SWEEP:    if (sts_i.sweep_last) state_d = ST_FLUSH;
      ST_FLUSH:    state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_req = accept;
    cmd_o.exec     = state_q == ST_EXEC;
    cmd_o.sweep_en = (state_q == ST_INIT) || (state_q == ST_SWEEP);
    cmd_o.load_out = (state_q == ST_DONE) && out_free;
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished item");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted item did not start execution");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && sts_i.sweep_last |=> state_q == ST_FLUSH)
    else $error("sweep did not end at the last cell");

  a_no_load_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !cmd_o.load_out)
    else $error("result register overwritten while held");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking regression for the text console character engine
// ----------------------------------------------------------------------------
// every accepted request updates a shadow copy of the 80x25 cell store and the
// cursor inside a small tracker class. the tracker queues the cursor report
// that the request should produce, and each result leaving the engine is
// compared field by field against the oldest queued report. a short directed
// run covers the edge codes and read indexes. three random phases follow,
// with different idle patterns on both channels and a different color
// attribute in each phase.
// ----------------------------------------------------------------------------
module tb_top;
  import tcce_pkg::*;

  localparam int MAX_SHOWN        = 10;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int HOLD_CYCLES      = 120;
  localparam int SETTLE_CYCLES    = 20;
  localparam int TAB_STOP         = 8;
  localparam int MAX_GAP          = 40;

  // shadow of the cell store and cursor, plus the queue of pending reports
  class console_tracker;
    logic [CELL_W-1:0] cells [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [7:0]        attr_reg;
    out_item_t         expected_reports [$];
    int unsigned       mismatches;
    int unsigned       n_puts;
    int unsigned       n_reads;
    int unsigned       n_scrolls;
    int unsigned       n_clears;
    int unsigned       n_wraps;

    function new();
      foreach (cells[i]) cells[i] = RESET_CELL;
      cur_col    = 0;
      cur_row    = 0;
      attr_reg   = DEFAULT_ATTR;
      mismatches = 0;
      n_puts     = 0;
      n_reads    = 0;
      n_scrolls  = 0;
      n_clears   = 0;
      n_wraps    = 0;
    endfunction

    // a zero attribute falls back to the default one
    function logic [7:0] eff_attr();
      return (attr_reg == 8'h00) ? DEFAULT_ATTR : attr_reg;
    endfunction

    function logic [CELL_W-1:0] blank_word();
      return {eff_attr(), CH_SPACE};
    endfunction

    function void shift_rows_up();
      for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = blank_word();
      cur_row = ROWS - 1;
      n_scrolls++;
    endfunction

    function void apply_char(logic [7:0] code);
      case (code)
        CH_BS: begin
          if (cur_col != 0) begin
            cur_col--;
            cells[cur_row * COLS + cur_col] = blank_word();
          end
        end
        CH_TAB: cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
        CH_CR:  cur_col = 0;
        CH_LF: begin
          cur_row++;
          cur_col = 0;
        end
        CH_FF: begin
          foreach (cells[i]) cells[i] = blank_word();
          cur_col = 0;
          cur_row = 0;
          n_clears++;
        end
        default: begin
          if (code >= CH_SPACE && code < CH_DEL_UP) begin
            cells[cur_row * COLS + cur_col] = {eff_attr(), code};
            cur_col++;
          end
        end
      endcase
      if (cur_col >= COLS) begin
        cur_row++;
        cur_col = 0;
        n_wraps++;
      end
      if (cur_row >= ROWS) shift_rows_up();
    endfunction

    function void note_request(in_item_t req);
      out_item_t         rep;
      logic [CELL_W-1:0] data;
      data = '0;
      if (req.req_type == REQ_PUT) begin
        n_puts++;
        apply_char(req.char_code);
      end else begin
        n_reads++;
        if (req.cell_index < CELLS) data = cells[req.cell_index];
      end
      rep.cursor_col      = COL_W'(cur_col);
      rep.cursor_row      = ROW_W'(cur_row);
      rep.cursor_location = ADDR_W'(cur_row * COLS + cur_col);
      rep.cell_data       = data;
      expected_reports.push_back(rep);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected report col %0d row %0d loc %0d data %h", $time,
                   got.cursor_col, got.cursor_row, got.cursor_location, got.cell_data);
        return;
      end
      want = expected_reports.pop_front();
      if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
          got.cursor_location !== want.cursor_location ||
          got.cell_data !== want.cell_data) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"%0t: report mismatch, want col %0d row %0d loc %0d data %h, ",
                    "got col %0d row %0d loc %0d data %h"},
                   $time, want.cursor_col, want.cursor_row, want.cursor_location,
                   want.cell_data, got.cursor_col, got.cursor_row, got.cursor_location,
                   got.cell_data);
      end
    endfunction
  endclass

  // dut side signals, the bench-driven ones known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = ADDR_ATTR;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  // idle percentages, set per phase by the main sequence
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // long receiver hold: the main sequence bumps the request count, the
  // receiver process serves it by counting cycles on its own
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  console_tracker tracker = new();

  text_console_char_engine dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_report(out_data_o);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // runaway guard, far beyond a run where every request triggers a full sweep
  initial begin
    #200_000_000;
    $display("text_console_char_engine regression: fail");
    $finish;
  end

  // offer one request, with an optional idle gap first, and return at the
  // edge where it transfers; valid stays high for a back-to-back request
  task automatic send_request(input in_item_t req);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(req);
  endtask

  // stop offering and wait until every queued report has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup then access cycle; the write lands when pready is seen high
  task automatic write_attribute(input logic [7:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_ATTR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.attr_reg = value;
  endtask

  function automatic in_item_t put_item(input logic [7:0] code);
    in_item_t req;
    req.req_type   = REQ_PUT;
    req.char_code  = code;
    req.cell_index = ADDR_W'($urandom);
    return req;
  endfunction

  function automatic in_item_t read_item(input logic [ADDR_W-1:0] idx);
    in_item_t req;
    req.req_type   = REQ_READ;
    req.char_code  = 8'($urandom);
    req.cell_index = idx;
    return req;
  endfunction

  // mostly printable text with line control mixed in, so the cursor walks
  // down the screen and scrolls; reads sample the store, a few out of range
  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      req = read_item(ADDR_W'($urandom_range(0, CELLS - 1)));
    end else if (pick < 12) begin
      req = read_item(ADDR_W'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 62)      req = put_item(8'($urandom_range(CH_SPACE, CH_DEL_UP - 1)));
      else if (pick < 68) req = put_item(CH_BS);
      else if (pick < 74) req = put_item(CH_TAB);
      else if (pick < 78) req = put_item(CH_CR);
      else if (pick < 86) req = put_item(CH_LF);
      else if (pick < 87) req = put_item(CH_FF);
      else if (pick < 93) req = put_item(8'($urandom_range(CH_DEL_UP, 8'hFF)));
      else                req = put_item(8'($urandom_range(0, CH_SPACE - 1)));
    end
    return req;
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // attribute goes in while the store is still being cleared
    write_attribute(8'h1E);

    // directed: read extremes on the reset store, then the edge codes
    send_request(read_item('0));
    send_request(read_item(LAST_CELL));
    send_request(read_item(ADDR_W'(CELLS)));
    send_request(read_item({ADDR_W{1'b1}}));
    send_request(put_item(CH_BS));               // backspace at column zero
    send_request(put_item(CH_SPACE));
    send_request(put_item(CH_DEL_UP - 1));
    send_request(put_item(8'h41));
    send_request(put_item(CH_BS));               // blanks the cell just written
    send_request(read_item(ADDR_W'(2)));
    send_request(read_item(ADDR_W'(1)));
    send_request(put_item(CH_TAB));
    send_request(put_item(CH_CR));
    send_request(put_item(CH_LF));
    send_request(put_item(8'h00));               // ignored controls
    send_request(put_item(CH_SPACE - 1));
    send_request(put_item(8'h0B));
    send_request(put_item(CH_DEL_UP));           // high codes are ignored
    send_request(put_item(8'hFF));
    send_request(put_item(CH_FF));               // clear and home
    send_request(read_item(ADDR_W'(1)));
    drain_results();

    // random phases: receiver-idle heavy, sender-idle heavy, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 50;
          write_attribute(8'hFF);
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 22;
          write_attribute(8'($urandom_range(1, 254)));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_attribute(8'h00);
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long result hold while requests keep coming, so the engine backs up
        if (n == 100) hold_requests++;
        // one pause in the middle until the engine has caught up
        if (phase == 1 && n == 200) drain_results();
        send_request(random_request());
      end
      drain_results();
    end

    $display("covered %0d transfers in: %0d puts, %0d reads",
             tracker.n_puts + tracker.n_reads, tracker.n_puts, tracker.n_reads);
    $display("line wraps %0d, scrolls %0d, screen clears %0d, mismatches %0d",
             tracker.n_wraps, tracker.n_scrolls, tracker.n_clears, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
      $display("text_console_char_engine regression: pass");
    end else begin
      $display("text_console_char_engine regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tcce_pkg.sv
rtl/core/tcce_dp.sv
rtl/core/tcce_ctrl.sv
rtl/core/text_console_char_engine.sv
tb/tb_top.sv
